// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the wavelet transform RTL.
// Every use expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cdwt_pkg.sv -----
// Package for the in-place Coiflet wavelet transform: widths, codes, types, helpers.
// Used by cdwt_mac and coiflet6_dwt_inplace_top; depends on nothing.
package cdwt_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int FRAC_DEF    = 16;

    localparam int DATA_W = 32;
    localparam int COEF_W = 18;
    localparam int PROD_W = DATA_W + COEF_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int LVL_W  = 4;
    localparam int NTAPS  = 6;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_BAD = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    localparam logic [2:0] REG_DIRECTION = 3'd0;
    localparam logic [2:0] REG_LEVELS    = 3'd1;
    localparam logic [2:0] REG_COEF0     = 3'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_SAVE,
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic valid;
        logic clr;
        logic last;
        logic neg;
    } mac_ctl_t;

    // Which coefficient multiplies tap k, for the scaling (half 0) or detail (half 1) sum.
    function automatic logic [2:0] coef_sel(input logic fwd, input logic half,
                                            input logic [2:0] k);
        logic [2:0] r;
        r = k;
        case ({fwd, half})
            2'b10: r = k;
            2'b11: r = 3'(5 - k);
            2'b00:
            begin
                case (k)
                    3'd0: r = 3'd4;
                    3'd4: r = 3'd0;
                    default: r = k;
                endcase
            end
            2'b01:
            begin
                case (k)
                    3'd0: r = 3'd5;
                    3'd1: r = 3'd0;
                    3'd2: r = 3'd3;
                    3'd3: r = 3'd2;
                    3'd4: r = 3'd1;
                    3'd5: r = 3'd4;
                    default: r = k;
                endcase
            end
            default: r = k;
        endcase
        return r;
    endfunction

    // Clamp an accumulator to 32 bits; the top bit of the result flags saturation.
    function automatic logic [DATA_W:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (x > hi)
            return {1'b1, hi[DATA_W-1:0]};
        else if (x < lo)
            return {1'b1, lo[DATA_W-1:0]};
        else
            return {1'b0, x[DATA_W-1:0]};
    endfunction

endpackage

// ----- rtl/coiflet6_dwt_inplace_top.sv -----
// Top level of the in-place periodic 6-tap Coiflet wavelet transform.
// Depends on cdwt_pkg, cdwt_mac and assert_macros.svh.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   tuser: mode; tdata: index, sample, count
// m_*      out  m_tvalid/m_tready   tdata: value, status
// cfg_*    in   cfg_we              cfg_addr register index, cfg_data value
//
// A write or an unused mode answers from the output register; a read answers after
// the registered memory read, through ST_RDWAIT. A run item reads per level 4 words
// to save, then per pair of output words fetches 6 taps from memory or the saved words,
// makes 12 passes through the single multiplier and drains its two-stage pipeline.
// Reset is asynchronous and clears control state and the registers; the sample
// memory is not cleared. The input is held off while a run goes on or while a
// result waits and is not being taken.
`include "assert_macros.svh"

module coiflet6_dwt_inplace_top #(
    parameter int MAX_LEN        = cdwt_pkg::MAX_LEN_DEF,
    parameter int COEF_FRAC_BITS = cdwt_pkg::FRAC_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // index [9:0], sample [41:10], count [52:42], zero fill
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value [31:0], status [33:32], zero fill
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [17:0] cfg_data
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int DW = cdwt_pkg::DATA_W;
    localparam int CW = cdwt_pkg::CNT_W;
    localparam int LW = cdwt_pkg::LVL_W;

    // Input fields.
    logic [cdwt_pkg::IDX_W-1:0] s_index;
    logic [DW-1:0]              s_sample;
    logic [CW-1:0]              s_count;
    logic                       s_acc;

    assign s_index  = s_tdata[9:0];
    assign s_sample = s_tdata[41:10];
    assign s_count  = s_tdata[52:42];
    assign s_acc    = s_tvalid & s_tready;

    // Configuration registers.
    logic                                dir_reg;
    logic [LW-1:0]                       levels_reg;
    logic signed [cdwt_pkg::COEF_W-1:0]  coef_reg [cdwt_pkg::NTAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= 1'b1;
            levels_reg <= LW'(1);
            for (int i = 0; i < cdwt_pkg::NTAPS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                cdwt_pkg::REG_DIRECTION: dir_reg    <= cfg_data[0];
                cdwt_pkg::REG_LEVELS:    levels_reg <= cfg_data[LW-1:0];
                default:
                    coef_reg[3'(cfg_addr - cdwt_pkg::REG_COEF0)] <= cfg_data;
            endcase
        end
    end

    // Sample memory, one write and one registered read port.
    logic [DW-1:0] mem [MAX_LEN];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // Sequencer state.
    cdwt_pkg::state_t state_reg, state_next;
    logic [LW-1:0]    lvl_reg, lvl_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    ii_reg, ii_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [3:0]       term_reg, term_next;
    logic             rsel_reg, rsel_next;
    logic             sat_reg, sat_next;
    logic             rd_ok_reg, rd_ok_next;
    logic [DW-1:0]    wrap_reg [4];
    logic [DW-1:0]    wrap_next [4];
    logic [DW-1:0]    v_reg [cdwt_pkg::NTAPS];
    logic [DW-1:0]    v_next [cdwt_pkg::NTAPS];

    // Pending memory or wrap read, landing in the cycle after issue.
    logic             ld_pend_reg, ld_pend_next;
    logic             ld_to_wrap_reg, ld_to_wrap_next;
    logic [2:0]       ld_dst_reg, ld_dst_next;
    logic             ld_from_wrap_reg, ld_from_wrap_next;
    logic [1:0]       ld_widx_reg, ld_widx_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [DW-1:0]    out_value_reg, out_value_next;
    logic [1:0]       out_status_reg, out_status_next;

    // Multiply-accumulate unit.
    cdwt_pkg::mac_ctl_t                 mac_ctl;
    logic signed [DW-1:0]               mac_a;
    logic signed [cdwt_pkg::COEF_W-1:0] mac_c;
    logic                               mac_res_valid;
    logic [DW-1:0]                      mac_res_value;
    logic                               mac_res_sat;

    cdwt_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .a         (mac_a),
        .c         (mac_c),
        .res_valid (mac_res_valid),
        .res_value (mac_res_value),
        .res_sat   (mac_res_sat)
    );

    // Word position (in units of the current stride) to memory address.
    function automatic logic [AW-1:0] u2a(input logic [CW:0] u, input logic [LW-1:0] l);
        logic [CW+15:0] w;
        w = {15'b0, u} << l;
        return w[AW-1:0];
    endfunction

    // Checks on a run item's count.
    logic [15:0]  blk_mask;
    logic         run_bad;
    logic [CW-1:0] m_len;
    logic [CW:0]   pos;
    logic [2:0]    tap;
    logic          half;
    logic [DW-1:0] ld_data;

    always_comb
    begin
        blk_mask = (16'(1) << levels_reg) - 16'd1;
        run_bad  = (levels_reg == '0) || (32'(s_count) > 32'(MAX_LEN))
                   || ((16'(s_count) & blk_mask) != 16'd0)
                   || ((s_count >> levels_reg) < CW'(3));
        m_len    = n_reg >> lvl_reg;
    end

    assign s_tready = (state_reg == cdwt_pkg::ST_IDLE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next        = state_reg;
        lvl_next          = lvl_reg;
        n_next            = n_reg;
        ii_next           = ii_reg;
        cnt_next          = cnt_reg;
        term_next         = term_reg;
        rsel_next         = rsel_reg;
        sat_next          = sat_reg;
        rd_ok_next        = rd_ok_reg;
        wrap_next         = wrap_reg;
        v_next            = v_reg;
        ld_pend_next      = 1'b0;
        ld_to_wrap_next   = ld_to_wrap_reg;
        ld_dst_next       = ld_dst_reg;
        ld_from_wrap_next = ld_from_wrap_reg;
        ld_widx_next      = ld_widx_reg;
        out_valid_next    = out_valid_reg;
        out_value_next    = out_value_reg;
        out_status_next   = out_status_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_raddr         = '0;
        mac_ctl           = '0;
        mac_a             = '0;
        mac_c             = '0;
        pos               = '0;
        tap               = '0;
        half              = 1'b0;

        if (m_tvalid && m_tready)
            out_valid_next = 1'b0;

        // Land the read issued last cycle.
        ld_data = ld_from_wrap_reg ? wrap_reg[ld_widx_reg] : rdata_reg;
        if (ld_pend_reg)
        begin
            if (ld_to_wrap_reg)
                wrap_next[ld_dst_reg[1:0]] = ld_data;
            else
                v_next[ld_dst_reg] = ld_data;
        end

        // The scaling word goes to position ii, the detail word to ii + 1.
        if (mac_res_valid)
        begin
            mem_we    = 1'b1;
            mem_waddr = u2a({1'b0, ii_reg} + (CW+1)'(rsel_reg), lvl_reg);
            mem_wdata = mac_res_value;
            sat_next  = sat_reg | mac_res_sat;
            rsel_next = ~rsel_reg;
        end

        case (state_reg)
            cdwt_pkg::ST_IDLE:
            begin
                if (s_acc)
                begin
                    out_value_next  = '0;
                    out_status_next = cdwt_pkg::STAT_OK;
                    case (s_tuser)
                        cdwt_pkg::MODE_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            if (32'(s_index) < 32'(MAX_LEN))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(s_index);
                                mem_wdata = s_sample;
                            end
                        end
                        cdwt_pkg::MODE_READ:
                        begin
                            mem_raddr  = AW'(s_index);
                            rd_ok_next = 32'(s_index) < 32'(MAX_LEN);
                            state_next = cdwt_pkg::ST_RDWAIT;
                        end
                        cdwt_pkg::MODE_RUN:
                        begin
                            if (run_bad)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = cdwt_pkg::STAT_BAD;
                            end
                            else
                            begin
                                n_next     = s_count;
                                lvl_next   = dir_reg ? '0 : LW'(levels_reg - LW'(1));
                                sat_next   = 1'b0;
                                cnt_next   = '0;
                                term_next  = '0;
                                rsel_next  = 1'b0;
                                state_next = cdwt_pkg::ST_SAVE;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            cdwt_pkg::ST_RDWAIT:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = rd_ok_reg ? rdata_reg : '0;
                out_status_next = cdwt_pkg::STAT_OK;
                state_next      = cdwt_pkg::ST_IDLE;
            end

            // Keep the four words that the wrap at the end of the level needs.
            cdwt_pkg::ST_SAVE:
            begin
                if (dir_reg)
                    pos = (CW+1)'(cnt_reg);
                else
                    pos = {1'b0, m_len} - (CW+1)'(1) - (CW+1)'(cnt_reg);
                mem_raddr         = u2a(pos, lvl_reg);
                ld_pend_next      = 1'b1;
                ld_to_wrap_next   = 1'b1;
                ld_from_wrap_next = 1'b0;
                ld_dst_next       = cnt_reg;
                cnt_next          = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    cnt_next   = '0;
                    ii_next    = dir_reg ? '0 : m_len - CW'(2);
                    state_next = cdwt_pkg::ST_LOAD;
                end
            end

            // Fetch the six taps of the pair, from memory or from the saved words.
            cdwt_pkg::ST_LOAD:
            begin
                pos               = {1'b0, ii_reg} + (CW+1)'(cnt_reg);
                ld_pend_next      = 1'b1;
                ld_to_wrap_next   = 1'b0;
                ld_dst_next       = cnt_reg;
                ld_from_wrap_next = 1'b0;
                if (dir_reg)
                begin
                    if (pos >= {1'b0, m_len})
                    begin
                        ld_from_wrap_next = 1'b1;
                        ld_widx_next      = 2'(pos - {1'b0, m_len});
                    end
                    else
                        mem_raddr = u2a(pos, lvl_reg);
                end
                else
                begin
                    if (pos < (CW+1)'(4))
                    begin
                        ld_from_wrap_next = 1'b1;
                        ld_widx_next      = 2'((CW+1)'(3) - pos);
                    end
                    else
                        mem_raddr = u2a(pos - (CW+1)'(4), lvl_reg);
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    cnt_next   = '0;
                    term_next  = '0;
                    state_next = cdwt_pkg::ST_MAC;
                end
            end

            // Six terms of the scaling sum, then six of the detail sum.
            cdwt_pkg::ST_MAC:
            begin
                half          = term_reg >= 4'd6;
                tap           = half ? 3'(term_reg - 4'd6) : term_reg[2:0];
                mac_ctl.valid = 1'b1;
                mac_ctl.clr   = tap == 3'd0;
                mac_ctl.last  = tap == 3'd5;
                mac_ctl.neg   = half & tap[0];
                mac_a         = v_reg[tap];
                mac_c         = coef_reg[cdwt_pkg::coef_sel(dir_reg, half, tap)];
                term_next     = term_reg + 4'd1;
                if (term_reg == 4'd11)
                begin
                    term_next  = '0;
                    state_next = cdwt_pkg::ST_DRAIN;
                end
            end

            cdwt_pkg::ST_DRAIN:
            begin
                if (mac_res_valid && rsel_reg)
                begin
                    if (dir_reg)
                    begin
                        if (({1'b0, ii_reg} + (CW+1)'(2)) >= {1'b0, m_len})
                        begin
                            if ((lvl_reg + LW'(1)) == levels_reg)
                                state_next = cdwt_pkg::ST_RESP;
                            else
                            begin
                                lvl_next   = lvl_reg + LW'(1);
                                state_next = cdwt_pkg::ST_SAVE;
                            end
                        end
                        else
                        begin
                            ii_next    = ii_reg + CW'(2);
                            state_next = cdwt_pkg::ST_LOAD;
                        end
                    end
                    else
                    begin
                        if (ii_reg == '0)
                        begin
                            if (lvl_reg == '0)
                                state_next = cdwt_pkg::ST_RESP;
                            else
                            begin
                                lvl_next   = lvl_reg - LW'(1);
                                state_next = cdwt_pkg::ST_SAVE;
                            end
                        end
                        else
                        begin
                            ii_next    = ii_reg - CW'(2);
                            state_next = cdwt_pkg::ST_LOAD;
                        end
                    end
                end
            end

            cdwt_pkg::ST_RESP:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = '0;
                out_status_next = sat_reg ? cdwt_pkg::STAT_SAT : cdwt_pkg::STAT_OK;
                state_next      = cdwt_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = cdwt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdwt_pkg::ST_IDLE;
            lvl_reg       <= '0;
            n_reg         <= '0;
            ii_reg        <= '0;
            cnt_reg       <= '0;
            term_reg      <= '0;
            rsel_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            rd_ok_reg     <= 1'b0;
            ld_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                wrap_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            n_reg         <= n_next;
            ii_reg        <= ii_next;
            cnt_reg       <= cnt_next;
            term_reg      <= term_next;
            rsel_reg      <= rsel_next;
            sat_reg       <= sat_next;
            rd_ok_reg     <= rd_ok_next;
            ld_pend_reg   <= ld_pend_next;
            out_valid_reg <= out_valid_next;
            wrap_reg      <= wrap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg            <= v_next;
        ld_to_wrap_reg   <= ld_to_wrap_next;
        ld_dst_reg       <= ld_dst_next;
        ld_from_wrap_reg <= ld_from_wrap_next;
        ld_widx_reg      <= ld_widx_next;
        out_value_reg    <= out_value_next;
        out_status_reg   <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_status_reg, out_value_reg};

    // Conditions the assertions below look at.
    logic in_pair;
    logic in_fetch;
    logic bad_acc;
    logic bad_out;

    assign in_pair  = (state_reg == cdwt_pkg::ST_MAC) || (state_reg == cdwt_pkg::ST_DRAIN);
    assign in_fetch = (state_reg == cdwt_pkg::ST_LOAD) || (state_reg == cdwt_pkg::ST_SAVE);
    assign bad_acc  = s_acc && (s_tuser == cdwt_pkg::MODE_RUN) && run_bad;
    assign bad_out  = m_tvalid && (out_status_reg == cdwt_pkg::STAT_BAD);

    // A finished sum arrives only while a pair is being computed.
    `ASSERT_IMP(a_res_in_run, mac_res_valid, in_pair, "MAC result outside a run")
    // Nothing is written back while taps or wrap words are being fetched.
    `ASSERT_IMP(a_no_wr_in_fetch, in_fetch, !mem_we, "memory write during fetch")
    // A run with a bad count answers at once with the bad-count status.
    `ASSERT_NXT(a_bad_count, bad_acc, bad_out, "bad count not reported")

endmodule

// ----- rtl/cdwt_mac.sv -----
// Shared multiply-accumulate unit: one product per cycle, rounded and summed.
// Depends on cdwt_pkg for widths, the control struct and the saturation helper.
module cdwt_mac #(
    parameter int COEF_FRAC_BITS = cdwt_pkg::FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdwt_pkg::mac_ctl_t                  ctl,
    input  logic signed [cdwt_pkg::DATA_W-1:0]  a,
    input  logic signed [cdwt_pkg::COEF_W-1:0]  c,
    output logic                                res_valid,
    output logic [cdwt_pkg::DATA_W-1:0]         res_value,
    output logic                                res_sat
);

    localparam int ACC_W  = cdwt_pkg::ACC_W;
    localparam int PROD_W = cdwt_pkg::PROD_W;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] p_reg;
    cdwt_pkg::mac_ctl_t       ctl1_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     last2_reg;
    logic signed [ACC_W-1:0]  pe;
    logic signed [ACC_W-1:0]  rnd;
    logic [cdwt_pkg::DATA_W:0] sat_res;

    // Rounding adds one half and floors, so halves round up.
    always_comb
    begin
        pe  = {{(ACC_W-PROD_W){p_reg[PROD_W-1]}}, p_reg};
        rnd = (pe + HALF) >>> COEF_FRAC_BITS;
        acc_next = (ctl1_reg.clr ? '0 : acc_reg) + (ctl1_reg.neg ? -rnd : rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg  <= '0;
            last2_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg  <= ctl;
            last2_reg <= ctl1_reg.valid & ctl1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= a * c;
        if (ctl1_reg.valid)
            acc_reg <= acc_next;
    end

    assign sat_res   = cdwt_pkg::sat32(acc_reg);
    assign res_valid = last2_reg;
    assign res_value = sat_res[cdwt_pkg::DATA_W-1:0];
    assign res_sat   = sat_res[cdwt_pkg::DATA_W];

endmodule
